/* design/annexb_nal_unit_splitter_macros.svh */
// assertion macros used by the splitter checker
`ifndef ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH

// plain property, sampled on clk_i, off while rst_ni is low
`define ANB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("annexb splitter check failed");

// same-cycle implication
`define ANB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("annexb splitter check failed");

`endif

/* design/annexb_pkg.sv */
// shared types and constants of the annex b nal unit splitter
package annexb_pkg;

  localparam int unsigned ZERO_PREFIX_W = 16;
  localparam int unsigned UNIT_LEN_W    = 24;
  localparam int unsigned NAL_TYPE_W    = 5;

  localparam logic [7:0]            BYTE_ZERO        = 8'h00;
  localparam logic [7:0]            START_CODE_LAST  = 8'h01;
  localparam logic [NAL_TYPE_W-1:0] NAL_TYPE_NON_IDR = 5'd1;
  localparam logic [NAL_TYPE_W-1:0] NAL_TYPE_IDR     = 5'd5;

  // byte class decided by the front end
  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_START,
    CLS_DATA
  } byte_cls_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    byte_cls_e  cls;
    logic [7:0] data;
    logic       fin;
  } mid_item_t;

  typedef struct packed {
    logic                     has_byte;
    logic [7:0]               payload_byte;
    logic [ZERO_PREFIX_W-1:0] zero_prefix;
    logic                     unit_first;
    logic [NAL_TYPE_W-1:0]    unit_type;
    logic                     unit_is_slice;
    logic                     unit_last;
    logic [UNIT_LEN_W-1:0]    unit_length;
  } out_item_t;

endpackage

/* design/annexb_fifo.sv */
// small register-based fifo used between the splitter stages
module annexb_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/annexb_front.sv */
// front end: accepts stream bytes and classifies them as zero, start code end or data
module annexb_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  annexb_pkg::in_item_t  in_item_i,
  input  logic                  mid_full_i,
  output logic                  mid_push_o,
  output annexb_pkg::mid_item_t mid_item_o
);

  // zero run length, saturating at two
  logic [1:0] zrun_q, zrun_d;
  logic       accept;
  logic       is_zero;
  logic       run_two;

  assign accept  = push_i & ~mid_full_i;
  assign is_zero = (in_item_i.stream_byte == annexb_pkg::BYTE_ZERO);
  assign run_two = (zrun_q == 2'd2);

  always_comb begin
    mid_item_o.data = in_item_i.stream_byte;
    mid_item_o.fin  = in_item_i.final_byte;
    if (is_zero) begin
      mid_item_o.cls = annexb_pkg::CLS_ZERO;
    end else if (in_item_i.stream_byte == annexb_pkg::START_CODE_LAST && run_two) begin
      mid_item_o.cls = annexb_pkg::CLS_START;
    end else begin
      mid_item_o.cls = annexb_pkg::CLS_DATA;
    end
  end

  always_comb begin
    zrun_d = zrun_q;
    if (accept) begin
      if (in_item_i.final_byte || !is_zero) begin
        zrun_d = 2'd0;
      end else if (!run_two) begin
        zrun_d = zrun_q + 2'd1;
      end
    end
  end

  assign mid_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zrun_q <= 2'd0;
    end else begin
      zrun_q <= zrun_d;
    end
  end

endmodule

/* design/annexb_back.sv */
// back end: tracks unit state and builds payload and end marker transactions
module annexb_back #(
  parameter int unsigned ZERO_RUN_BITS = 16,
  parameter int unsigned LENGTH_BITS   = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  annexb_pkg::mid_item_t mid_item_i,
  input  logic                  mid_empty_i,
  output logic                  mid_pop_o,
  input  logic                  out_full_i,
  output logic                  out_push_o,
  output annexb_pkg::out_item_t out_item_o
);

  localparam int unsigned ZPW = (ZERO_RUN_BITS > annexb_pkg::ZERO_PREFIX_W) ?
                                ZERO_RUN_BITS : annexb_pkg::ZERO_PREFIX_W;
  localparam int unsigned LPW = (LENGTH_BITS > annexb_pkg::UNIT_LEN_W) ?
                                LENGTH_BITS : annexb_pkg::UNIT_LEN_W;
  localparam int unsigned SW  = ((LENGTH_BITS > ZERO_RUN_BITS + 1) ?
                                LENGTH_BITS : ZERO_RUN_BITS + 1) + 1;

  logic                               inside_q, inside_d, inside_n;
  logic [ZERO_RUN_BITS-1:0]           pend_q, pend_d, pend_n;
  logic [LENGTH_BITS-1:0]             bytes_q, bytes_d, bytes_n;
  logic [annexb_pkg::NAL_TYPE_W-1:0]  type_q, type_d, type_n;
  logic                               go;
  logic                               emit, has_byte, first;
  logic                               unit_open;
  logic [SW-1:0]                      len_sum;
  logic [ZPW-1:0]                     zp_ext;
  logic [LPW-1:0]                     len_ext;

  assign go        = ~mid_empty_i & ~out_full_i;
  assign mid_pop_o = go;
  assign unit_open = inside_q & (bytes_q != '0);
  assign first     = (bytes_q == '0);
  // length plus this byte and its zero prefix
  assign len_sum   = SW'(bytes_q) + SW'(pend_q) + SW'(1);

  always_comb begin
    inside_n = inside_q;
    pend_n   = pend_q;
    bytes_n  = bytes_q;
    type_n   = type_q;
    emit     = 1'b0;
    has_byte = 1'b0;
    case (mid_item_i.cls)
      annexb_pkg::CLS_ZERO: begin
        pend_n = (&pend_q) ? pend_q : pend_q + ZERO_RUN_BITS'(1);
        emit   = mid_item_i.fin & unit_open;
      end
      annexb_pkg::CLS_START: begin
        emit     = unit_open;
        inside_n = 1'b1;
        bytes_n  = '0;
        pend_n   = '0;
      end
      annexb_pkg::CLS_DATA: begin
        if (inside_q) begin
          emit     = 1'b1;
          has_byte = 1'b1;
          if (first) begin
            type_n = (pend_q != '0) ? '0 : mid_item_i.data[annexb_pkg::NAL_TYPE_W-1:0];
          end
          bytes_n = (len_sum > SW'({LENGTH_BITS{1'b1}})) ? {LENGTH_BITS{1'b1}} :
                    len_sum[LENGTH_BITS-1:0];
        end
        pend_n = '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // buffer end returns everything to reset
  always_comb begin
    if (mid_item_i.fin) begin
      inside_d = 1'b0;
      pend_d   = '0;
      bytes_d  = '0;
      type_d   = '0;
    end else begin
      inside_d = inside_n;
      pend_d   = pend_n;
      bytes_d  = bytes_n;
      type_d   = type_n;
    end
  end

  assign zp_ext  = ZPW'(pend_q);
  // an end marker reports the length of the closing unit, before a start code clears it
  assign len_ext = LPW'(has_byte ? bytes_n : bytes_q);

  always_comb begin
    out_item_o.has_byte      = has_byte;
    out_item_o.payload_byte  = has_byte ? mid_item_i.data : 8'h00;
    out_item_o.zero_prefix   = has_byte ? zp_ext[annexb_pkg::ZERO_PREFIX_W-1:0] : '0;
    out_item_o.unit_first    = has_byte & first;
    out_item_o.unit_type     = type_n;
    out_item_o.unit_is_slice = type_n inside {annexb_pkg::NAL_TYPE_NON_IDR,
                                              annexb_pkg::NAL_TYPE_IDR};
    out_item_o.unit_last     = ~has_byte | mid_item_i.fin;
    out_item_o.unit_length   = len_ext[annexb_pkg::UNIT_LEN_W-1:0];
  end

  assign out_push_o = go & emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      pend_q   <= '0;
      bytes_q  <= '0;
      type_q   <= '0;
    end else if (go) begin
      inside_q <= inside_d;
      pend_q   <= pend_d;
      bytes_q  <= bytes_d;
      type_q   <= type_d;
    end
  end

endmodule

/* design/annexb_nal_unit_splitter.sv */
// top level of the annex b nal unit splitter
//
// usage
//   input side is a queue write port: drive in_item_i and push; a transaction
//   completes on a rising edge with push high and full low. one raw stream
//   byte per transaction, final_byte set on the last byte of a buffer.
//   result side is a queue read port: while empty is low out_item_o holds
//   the oldest result; it completes on a rising edge with pop high.
//   each byte gives zero or one result: a payload byte with its zero prefix,
//   or an end marker (has_byte low) when a start code or buffer end closes
//   a unit that has payload.
// timing
//   one byte per cycle sustained while pop keeps up. the accepting edge
//   writes a byte into the two-entry classify queue; the unit tracker
//   consumes it once the output queue has room and writes its result
//   into the two-entry output queue, where the receiver sees it.
//   unless stalled, the single tracker step sets rate: one byte per cycle.
// stalls and reset
//   with pop held low the output queue fills, the tracker stops and the
//   classify queue fills, then full rises; nothing is dropped.
//   reset empties both queues and returns the tracker to outside any unit.
module annexb_nal_unit_splitter #(
  parameter int unsigned ZERO_RUN_BITS = 16,
  parameter int unsigned LENGTH_BITS   = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  annexb_pkg::in_item_t  in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output annexb_pkg::out_item_t out_item_o
);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MidW       = $bits(annexb_pkg::mid_item_t);
  localparam int unsigned OutW       = $bits(annexb_pkg::out_item_t);

  // front to classify queue
  logic                  mid_push;
  logic                  mid_full;
  annexb_pkg::mid_item_t mid_wr_item;
  // classify queue to tracker
  logic                  mid_pop;
  logic                  mid_empty;
  logic [MidW-1:0]       mid_rd_raw;
  annexb_pkg::mid_item_t mid_rd_item;
  // tracker to output queue
  logic                  out_push;
  logic                  out_full;
  annexb_pkg::out_item_t out_wr_item;
  logic [OutW-1:0]       out_rd_raw;

  assign full = mid_full;

  // byte classification, start code detection
  annexb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .mid_full_i (mid_full),
    .mid_push_o (mid_push),
    .mid_item_o (mid_wr_item)
  );

  // decouples the front from tracker stalls
  annexb_fifo #(
    .Width (MidW),
    .Depth (QueueDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (MidW'(mid_wr_item)),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rd_raw),
    .empty_o (mid_empty)
  );

  assign mid_rd_item = annexb_pkg::mid_item_t'(mid_rd_raw);

  // unit state: zero runs, lengths, type, trimming
  annexb_back #(
    .ZERO_RUN_BITS (ZERO_RUN_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_item_i  (mid_rd_item),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_item_o  (out_wr_item)
  );

  // result queue, holds results while the receiver stalls
  annexb_fifo #(
    .Width (OutW),
    .Depth (QueueDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (OutW'(out_wr_item)),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rd_raw),
    .empty_o (empty)
  );

  assign out_item_o = annexb_pkg::out_item_t'(out_rd_raw);

endmodule

/* design/annexb_checker.sv */
// port-level checks of the splitter and their binding
`include "annexb_nal_unit_splitter_macros.svh"

module annexb_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  push,
  input logic                  full,
  input annexb_pkg::in_item_t  in_item_i,
  input logic                  empty,
  input logic                  pop,
  input annexb_pkg::out_item_t out_item_o
);

  // end marker carries no byte, prefix or open flag and always closes
  `ANB_ASSERT_IMP(a_marker_shape, !empty && !out_item_o.has_byte, out_item_o.unit_last && !out_item_o.unit_first && out_item_o.payload_byte == 8'h00 && out_item_o.zero_prefix == '0)

  // zeros travel only as a prefix count
  `ANB_ASSERT_IMP(a_payload_nonzero, !empty && out_item_o.has_byte, out_item_o.payload_byte != 8'h00)

  // a unit opens only on a payload transaction
  `ANB_ASSERT_IMP(a_first_has_byte, !empty && out_item_o.unit_first, out_item_o.has_byte && out_item_o.unit_length != '0)

  `ANB_ASSERT_IMP(a_slice_flag, !empty, out_item_o.unit_is_slice == (out_item_o.unit_type == annexb_pkg::NAL_TYPE_NON_IDR || out_item_o.unit_type == annexb_pkg::NAL_TYPE_IDR))

  // a waiting result stays put until popped
  `ANB_ASSERT(a_hold_stalled, (!empty && !pop) |=> (!empty && $stable(out_item_o)))

endmodule

bind annexb_nal_unit_splitter annexb_checker u_annexb_checker (.*);

/* dv/testbench.sv */
// self-checking testbench for the annex b nal unit splitter
module testbench;
  import annexb_pkg::*;

  // one stimulus transaction; steady ones go out with no sender gaps
  typedef struct {
    in_item_t item;
    bit       steady;
  } stim_t;

  // tracks units the way the splitter should and checks what comes out
  class nal_scoreboard;
    bit                       in_unit;
    logic [ZERO_PREFIX_W-1:0] zero_run;
    logic [UNIT_LEN_W-1:0]    unit_bytes;
    logic [NAL_TYPE_W-1:0]    unit_nal_type;
    out_item_t                expected_q[$];
    int                       mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      in_unit       = 1'b0;
      zero_run      = '0;
      unit_bytes    = '0;
      unit_nal_type = '0;
    endfunction

    function void add_expected(out_item_t r);
      expected_q.insert(expected_q.size(), r);
    endfunction

    function out_item_t unit_result(bit has, logic [7:0] b, logic [ZERO_PREFIX_W-1:0] zp,
                                    bit first, bit last);
      out_item_t r;
      r.has_byte      = has;
      r.payload_byte  = b;
      r.zero_prefix   = zp;
      r.unit_first    = first;
      r.unit_type     = unit_nal_type;
      r.unit_is_slice = (unit_nal_type == NAL_TYPE_NON_IDR) || (unit_nal_type == NAL_TYPE_IDR);
      r.unit_last     = last;
      r.unit_length   = unit_bytes;
      return r;
    endfunction

    function string describe(out_item_t r);
      return $sformatf("has=%0d byte=%h zp=%0d first=%0d type=%0d slice=%0d last=%0d len=%0d",
                       r.has_byte, r.payload_byte, r.zero_prefix, r.unit_first, r.unit_type,
                       r.unit_is_slice, r.unit_last, r.unit_length);
    endfunction

    function void note_input(in_item_t it);
      bit                  first;
      logic [UNIT_LEN_W:0] sum;
      if (it.stream_byte == BYTE_ZERO) begin
        if (zero_run != '1) zero_run++;
        // zero as the last byte of a buffer closes an open unit
        if (it.final_byte && in_unit && unit_bytes != 0)
          add_expected(unit_result(1'b0, '0, '0, 1'b0, 1'b1));
      end else if (it.stream_byte == START_CODE_LAST && zero_run >= 2) begin
        if (in_unit && unit_bytes != 0)
          add_expected(unit_result(1'b0, '0, '0, 1'b0, 1'b1));
        in_unit    = 1'b1;
        unit_bytes = '0;
        zero_run   = '0;
      end else begin
        if (in_unit) begin
          first = (unit_bytes == 0);
          // a unit that opens with zeros has type zero
          if (first)
            unit_nal_type = (zero_run != 0) ? '0 : it.stream_byte[NAL_TYPE_W-1:0];
          sum        = (UNIT_LEN_W+1)'(unit_bytes) + (UNIT_LEN_W+1)'(zero_run) +
                       (UNIT_LEN_W+1)'(1);
          unit_bytes = sum[UNIT_LEN_W] ? '1 : sum[UNIT_LEN_W-1:0];
          add_expected(unit_result(1'b1, it.stream_byte, zero_run, first, it.final_byte));
        end
        zero_run = '0;
      end
      if (it.final_byte) clear_state();
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      bit        bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      want = expected_q.pop_front();
      bad = (got.has_byte !== want.has_byte) || (got.payload_byte !== want.payload_byte) ||
            (got.zero_prefix !== want.zero_prefix) || (got.unit_first !== want.unit_first) ||
            (got.unit_type !== want.unit_type) || (got.unit_is_slice !== want.unit_is_slice) ||
            (got.unit_last !== want.unit_last) || (got.unit_length !== want.unit_length);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch\n  expected %s\n  actual   %s", describe(want), describe(got));
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      push      = 1'b0;
  logic      pop       = 1'b0;
  in_item_t  in_item_i = '0;
  logic      full;
  logic      empty;
  out_item_t out_item_o;

  nal_scoreboard sb;
  stim_t         stim_q[$];
  int            hold_at;
  int            run_limit;
  bit            stim_ready = 1'b0;
  int            n_sent     = 0;   // accepted input transactions
  bit            calm       = 1'b0; // no idling on either side near the end
  bit            rx_hold    = 1'b0; // long receiver hold-off
  int            rx_gap     = 0;
  int            rx_quiet   = 0;

  annexb_nal_unit_splitter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- stimulus build

  task automatic add_byte(input logic [7:0] b, input bit fin = 1'b0, input bit steady = 1'b0);
    stim_t s;
    s.item.stream_byte = b;
    s.item.final_byte  = fin;
    s.steady           = steady;
    stim_q.insert(stim_q.size(), s);
  endtask

  // zeros then 01: two zeros give the short form, three the long form
  task automatic add_start_code(input int zeros);
    repeat (zeros) add_byte(BYTE_ZERO);
    add_byte(START_CODE_LAST);
  endtask

  // payload byte biased toward zeros, 01 and the emulation prevention byte 03
  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 11))
      0, 1, 2: return BYTE_ZERO;
      3:       return START_CODE_LAST;
      4:       return 8'h03;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one buffer: mostly well-formed units with random content, sometimes raw noise
  task automatic add_random_buffer(inout int counted);
    int         len;
    int         first_idx;
    logic [7:0] hdr;
    logic [7:0] r;
    if ($urandom_range(0, 9) == 0) begin
      // noise, final flag anywhere
      len = $urandom_range(1, 24);
      repeat (len) add_byte(body_byte(), $urandom_range(0, 15) == 0);
      return;
    end
    // junk before the first start code is dropped by the block
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(2, 255)));
    first_idx = stim_q.size();
    repeat ($urandom_range(1, 4)) begin
      add_start_code($urandom_range(2, 4));
      // an empty unit now and then
      if ($urandom_range(0, 9) != 0) begin
        r = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
          0:       hdr = BYTE_ZERO;
          1:       hdr = r;
          2:       hdr = {1'b0, r[6:5], NAL_TYPE_NON_IDR};
          3:       hdr = {1'b0, r[6:5], NAL_TYPE_IDR};
          default: hdr = {1'b0, r[6:5], 5'($urandom_range(6, 12))};
        endcase
        add_byte(hdr);
        len = $urandom_range(0, 12);
        repeat (len) add_byte(body_byte());
        // trailing zeros that must be trimmed
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) add_byte(BYTE_ZERO);
      end
    end
    // how the buffer ends
    case ($urandom_range(0, 3))
      0: stim_q[stim_q.size()-1].item.final_byte = 1'b1;
      1: add_byte(BYTE_ZERO, 1'b1);
      2: begin
        add_byte(BYTE_ZERO);
        add_byte(BYTE_ZERO);
        add_byte(START_CODE_LAST, 1'b1);
      end
      default: add_byte(8'($urandom_range(2, 255)), 1'b1);
    endcase
    counted += stim_q.size() - first_idx;
  endtask

  // ---------------------------------------------------------------- input side

  // offer one transaction and hold it until the block takes it
  task automatic send_item(input stim_t s);
    push      <= 1'b1;
    in_item_i <= s.item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_input(s.item);
    n_sent <= n_sent + 1;
  endtask

  task automatic idle_for(input int n);
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    int counted;
    int steady_n;
    sb = new();

    // a lone zero then 01 is not a start code, still outside any unit
    add_byte(BYTE_ZERO);
    add_byte(START_CODE_LAST);
    // short start code, idr slice header, zeros passed on as a prefix
    add_start_code(2);
    add_byte(8'h65);
    add_byte(BYTE_ZERO);
    add_byte(BYTE_ZERO);
    add_byte(8'h03);
    // long start code closes the unit, the extra zero is trimmed
    add_start_code(3);
    // empty unit, no end marker
    add_start_code(2);
    // unit opening with a zero byte gets type zero
    add_byte(BYTE_ZERO);
    add_byte(8'h41);
    // start code completed on the final byte closes the unit
    add_byte(BYTE_ZERO);
    add_byte(BYTE_ZERO);
    add_byte(START_CODE_LAST, 1'b1);
    // all-ones byte, then a zero as final byte
    add_start_code(2);
    add_byte(8'hff);
    add_byte(BYTE_ZERO, 1'b1);

    hold_at = stim_q.size() + 100;
    counted = 0;
    while (counted < 650) add_random_buffer(counted);

    steady_n = 0;
    foreach (stim_q[i]) if (stim_q[i].steady) steady_n++;
    run_limit  = 150 * (stim_q.size() - steady_n) + 3 * steady_n + 20000;
    stim_ready = 1'b1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_q[i]) begin
      // sender gaps, none while the receiver is held off so the block fills
      if (!stim_q[i].steady && !calm && !rx_hold && $urandom_range(0, 7) == 0)
        idle_for($urandom_range(1, 17));
      if (i + 120 >= stim_q.size()) calm <= 1'b1;
      send_item(stim_q[i]);
    end
    push <= 1'b0;

    // drain, then keep watching to catch stray results
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("annexb_nal_unit_splitter regression: pass");
    else
      $display("annexb_nal_unit_splitter regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------- result side

  // pops with random bursts of idling and stretches of steady popping
  always @(posedge clk_i) begin
    if (pop && !empty) sb.check_result(out_item_o);
    if (!rst_ni || rx_hold) begin
      pop <= 1'b0;
    end else if (rx_gap > 0) begin
      pop    <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (rx_quiet > 0) begin
      pop      <= 1'b1;
      rx_quiet <= rx_quiet - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop    <= 1'b0;
      rx_gap <= $urandom_range(0, 16);
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 31) == 0) rx_quiet <= $urandom_range(20, 120);
    end
  end

  // long receiver hold-off early in the random part
  initial begin
    wait (stim_ready);
    while (n_sent < hold_at) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // watchdog
  initial begin
    int cycle_cnt;
    wait (stim_ready);
    cycle_cnt = 0;
    while (cycle_cnt < run_limit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("annexb_nal_unit_splitter regression: fail");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/annexb_pkg.sv
design/annexb_fifo.sv
design/annexb_front.sv
design/annexb_back.sv
design/annexb_nal_unit_splitter.sv
design/annexb_checker.sv
dv/testbench.sv
